[src/sdg_pkg.sv]
// Shared constants, command codes and control types for the step/dir generator.
package sdg_pkg;

   // Default parameter values
   localparam int unsigned DEF_POSITION_MAX     = 100000;
   localparam int unsigned DEF_PULSE_TICKS      = 5;
   localparam int unsigned DEF_TICKS_PER_SECOND = 1000000;

   // Field widths fixed by the interface
   localparam int unsigned CMD_W    = 8;
   localparam int unsigned SPEED_W  = 11;
   localparam int unsigned PERIOD_W = 15;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned IDX_W    = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_POS_LO = 8'd70;
   localparam logic [CMD_W-1:0] CMD_POS_HI = 8'd100;
   localparam logic [CMD_W-1:0] CMD_SPD_LO = 8'd101;
   localparam logic [CMD_W-1:0] CMD_SPD_HI = 8'd120;
   localparam logic [CMD_W-1:0] CMD_HOME   = 8'd121;
   localparam logic [CMD_W-1:0] CMD_STOP   = 8'd122;

   // Scaling constants
   localparam int unsigned POS_SPAN   = 30;
   localparam int unsigned SPD_SPAN   = 19;
   localparam int unsigned SPEED_STEP = 1950;
   localparam logic [SPEED_W-1:0]  SPEED_LO     = 11'd50;
   localparam logic [SPEED_W-1:0]  SPEED_RESET  = 11'd500;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd2000;
   localparam logic [PERIOD_W-1:0] PERIOD_LIMIT = 15'd32767;

   // Divisor width: the largest divisor is the top speed
   localparam int unsigned DSR_W = SPEED_W;

   // Reported status
   localparam logic [STATUS_W-1:0] STATUS_IDLE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MOVING = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HOMING = 2'd2;

   // Item kinds: only a speed command needs the divider
   localparam logic [1:0] KIND_FAST = 2'd0;
   localparam logic [1:0] KIND_POS  = 2'd1;
   localparam logic [1:0] KIND_SPD  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic       commit_fast;
      logic       commit_div;
      logic       capture;
      logic       div_start;
   } sdg_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] req_kind;
      logic       out_free;
      logic       div_done;
   } sdg_stat_type;

   // Classify an input beat
   function automatic logic [1:0] item_kind(input logic op, input logic [CMD_W-1:0] cmd);
      logic [1:0] kind;
      kind = KIND_FAST;
      if (!op) begin
         if (cmd >= CMD_POS_LO && cmd <= CMD_POS_HI) begin
            kind = KIND_POS;
         end else if (cmd >= CMD_SPD_LO && cmd <= CMD_SPD_HI) begin
            kind = KIND_SPD;
         end
      end
      return kind;
   endfunction

endpackage

[src/sdg_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module sdg_div
   import sdg_pkg::*;
#(
   parameter int unsigned DW   = 27,
   parameter int unsigned DS_W = 11
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DW-1:0]   dividend,
   input  logic [DS_W-1:0] divisor,
   output logic            done,
   output logic [DW-1:0]   quotient
);

   localparam int unsigned CNT_W = (DW > 1) ? $clog2(DW) : 1;

   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [DS_W-1:0]  rem_ff, rem_in;
   logic [DS_W-1:0]  dsr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DS_W:0]    rem_sh;
   logic [DS_W:0]    rem_diff;
   logic             fits;

   // One shift-and-subtract step
   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[DW-1]};
      rem_diff = rem_sh - {1'b0, dsr_ff};
      fits     = rem_sh >= {1'b0, dsr_ff};
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DW-2:0], fits};
         rem_in = fits ? rem_diff[DS_W-1:0] : rem_sh[DS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

   // The done pulse only closes a running division
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

[src/sdg_ctrl.sv]
// Sequencing state machine: accepts beats, runs divisions, commits results.
module sdg_ctrl
   import sdg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sdg_stat_type stat,
   output sdg_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = !(state_ff == ST_IDLE && stat.out_free);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (stat.req_kind == KIND_SPD) begin
                  // speed from the table, step period from the divider
                  cmd.capture   = 1'b1;
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  cmd.commit_fast = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.commit_div = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A division result only arrives while one is awaited
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == ST_DIV))
      else $error("division finished outside the division state");

   // Commits happen in IDLE or DONE only
   a_commit_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_fast || cmd.commit_div) |-> (state_ff == ST_IDLE || state_ff == ST_DONE))
      else $error("commit outside IDLE or DONE");

endmodule

[src/sdg_dp.sv]
// Motion datapath: position/step state, divider operands and the result register.
module sdg_dp
   import sdg_pkg::*;
#(
   parameter int unsigned POSITION_MAX     = DEF_POSITION_MAX,
   parameter int unsigned PULSE_TICKS      = DEF_PULSE_TICKS,
   parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
   localparam int unsigned POS_W = $clog2(POSITION_MAX + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  sdg_cmd_type         cmd,
   output sdg_stat_type        stat,
   input  logic                req_op,
   input  logic [CMD_W-1:0]    req_command,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_step_out,
   output logic                rsp_direction,
   output logic [POS_W-1:0]    rsp_position,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SPEED_W-1:0]  rsp_speed,
   output logic                rsp_unknown_command
);

   // Divider width covers the tick rate and the saturation compare
   localparam int unsigned DW_RAW = $clog2(TICKS_PER_SECOND + 1);
   localparam int unsigned DW     = (DW_RAW > PERIOD_W) ? DW_RAW : PERIOD_W;
   localparam int unsigned TC_W   = $clog2(PULSE_TICKS + (2 ** PERIOD_W));

   // Architectural state
   logic [POS_W-1:0]    pos_ff, target_ff;
   logic [SPEED_W-1:0]  speed_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [TC_W-1:0]     tick_ff;
   logic                moving_ff, homing_ff, dir_ff;
   logic [SPEED_W-1:0]  speed_new_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // Next values
   logic [POS_W-1:0]    pos_in, target_in, goal;
   logic [SPEED_W-1:0]  speed_in;
   logic [PERIOD_W-1:0] period_in;
   logic [TC_W-1:0]     tick_in, tick_inc, tick_lim;
   logic                moving_in, homing_in, dir_in, do_move;
   logic                step_in, unknown_in;
   logic [PERIOD_W-1:0] period_sat;
   logic [1:0]          req_kind;

   // Lookup tables and divider operands
   logic [POS_W-1:0]    pos_tab [POS_SPAN+1];
   logic [SPEED_W-1:0]  spd_tab [SPD_SPAN+1];
   logic [IDX_W-1:0]    pos_idx, spd_idx;
   logic [SPEED_W-1:0]  speed_pick;
   logic [DW-1:0]       div_dividend, div_quot;
   logic                div_done;
   logic                commit;

   // Target and speed for every code of the two command ranges
   for (genvar g = 0; g <= POS_SPAN; g++) begin : g_pos_tab
      assign pos_tab[g] = POS_W'((g * POSITION_MAX) / POS_SPAN);
   end

   for (genvar g = 0; g <= SPD_SPAN; g++) begin : g_spd_tab
      assign spd_tab[g] = SPEED_W'(SPEED_LO + (g * SPEED_STEP) / SPD_SPAN);
   end

   assign req_kind     = item_kind(req_op, req_command);
   assign pos_idx      = IDX_W'(req_command - CMD_POS_LO);
   assign spd_idx      = IDX_W'(req_command - CMD_SPD_LO);
   assign speed_pick   = spd_tab[spd_idx];
   assign div_dividend = DW'(TICKS_PER_SECOND);
   assign period_sat = (div_quot > DW'(PERIOD_LIMIT)) ? PERIOD_LIMIT : div_quot[PERIOD_W-1:0];

   // Step period: tick rate over the new speed
   sdg_div #(
      .DW   (DW),
      .DS_W (DSR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (speed_pick),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Next architectural state and result fields
   always_comb begin
      pos_in     = pos_ff;
      target_in  = target_ff;
      speed_in   = speed_ff;
      period_in  = period_ff;
      tick_in    = tick_ff;
      moving_in  = moving_ff;
      homing_in  = homing_ff;
      dir_in     = dir_ff;
      step_in    = 1'b0;
      unknown_in = 1'b0;
      do_move    = 1'b0;
      goal       = '0;
      tick_inc   = tick_ff + 1'b1;
      tick_lim   = TC_W'(PULSE_TICKS) + TC_W'(period_ff);

      if (cmd.commit_fast) begin
         if (req_op) begin
            // Step phase advance
            if (moving_ff) begin
               step_in = tick_ff < TC_W'(PULSE_TICKS);
               tick_in = tick_inc;
               if (tick_inc >= tick_lim) begin
                  tick_in = '0;
                  if (dir_ff) begin
                     pos_in = pos_ff + 1'b1;
                  end else if (pos_ff != '0) begin
                     pos_in = pos_ff - 1'b1;
                  end
                  if (pos_in == target_ff) begin
                     moving_in = 1'b0;
                     homing_in = 1'b0;
                  end
               end
            end
         end else if (req_kind == KIND_POS) begin
            do_move = 1'b1;
            goal    = pos_tab[pos_idx];
         end else if (req_command == CMD_HOME) begin
            homing_in = 1'b1;
            do_move   = 1'b1;
         end else if (req_command == CMD_STOP) begin
            moving_in = 1'b0;
            homing_in = 1'b0;
            tick_in   = '0;
         end else begin
            unknown_in = 1'b1;
         end
      end else if (cmd.commit_div) begin
         speed_in  = speed_new_ff;
         period_in = period_sat;
      end

      // Start of a move toward goal
      if (do_move) begin
         target_in = goal;
         tick_in   = '0;
         if (goal == pos_ff) begin
            moving_in = 1'b0;
            homing_in = 1'b0;
         end else begin
            dir_in    = goal > pos_ff;
            moving_in = 1'b1;
         end
      end
   end

   assign commit       = cmd.commit_fast || cmd.commit_div;
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         target_ff    <= '0;
         speed_ff     <= SPEED_RESET;
         period_ff    <= PERIOD_RESET;
         tick_ff      <= '0;
         moving_ff    <= 1'b0;
         homing_ff    <= 1'b0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            pos_ff    <= pos_in;
            target_ff <= target_in;
            speed_ff  <= speed_in;
            period_ff <= period_in;
            tick_ff   <= tick_in;
            moving_ff <= moving_in;
            homing_ff <= homing_in;
            dir_ff    <= dir_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured new speed and the result beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         speed_new_ff <= speed_pick;
      end
      if (commit) begin
         rsp_step_out        <= step_in;
         rsp_direction       <= dir_in;
         rsp_position        <= pos_in;
         rsp_status          <= homing_in ? STATUS_HOMING :
                                (moving_in ? STATUS_MOVING : STATUS_IDLE);
         rsp_speed           <= speed_in;
         rsp_unknown_command <= unknown_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign stat.req_kind = req_kind;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign stat.div_done = div_done;

   // Homing is always a kind of move
   a_homing_moving: assert property (@(posedge clock) disable iff (reset)
      homing_ff |-> moving_ff)
      else $error("homing flag set without a move");

   // Position stays inside the travel range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(POSITION_MAX) && target_ff <= POS_W'(POSITION_MAX))
      else $error("position or target beyond travel range");

endmodule

[src/stepper_step_dir_generator_core.sv]
// Top level of the stepper step/direction pulse generator.
//
// Input channel (req_): one beat is either a command code (req_op = 0) or a
// one-microsecond tick (req_op = 1). Result channel (rsp_): exactly one beat
// per input beat, carrying step line level, direction, position, status,
// speed and the unknown-command flag after that input took effect.
// Ticks, position, home, stop and unknown codes commit on acceptance: the result
// is in the output register at the edge after acceptance, and such beats can
// follow at one per cycle while the output is not stalled. Position targets and
// speeds come from small constant tables. A speed command also runs one pass of
// the serial divider for the step period, one quotient bit per cycle over DW bits
// (DW = 20 at the default tick rate); its result is committed once the divider is
// done and the output register is free, and no new beat is taken until then.
// A new beat is taken while the previous result still waits, as long as the
// output register is empty or being drained in that cycle; a stalled result
// holds and req_stall rises until it leaves. Reset returns position and
// target to 0, speed to 500 steps/s, period to 2000 ticks, idle status.
module stepper_step_dir_generator_core
   import sdg_pkg::*;
#(
   parameter int unsigned POSITION_MAX     = DEF_POSITION_MAX,
   parameter int unsigned PULSE_TICKS      = DEF_PULSE_TICKS,
   parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
   localparam int unsigned POS_W = $clog2(POSITION_MAX + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [CMD_W-1:0]    req_command,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_step_out,
   output logic                rsp_direction,
   output logic [POS_W-1:0]    rsp_position,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SPEED_W-1:0]  rsp_speed,
   output logic                rsp_unknown_command
);

   sdg_cmd_type  cmd;
   sdg_stat_type stat;

   sdg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdg_dp #(
      .POSITION_MAX     (POSITION_MAX),
      .PULSE_TICKS      (PULSE_TICKS),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_op              (req_op),
      .req_command         (req_command),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_step_out        (rsp_step_out),
      .rsp_direction       (rsp_direction),
      .rsp_position        (rsp_position),
      .rsp_status          (rsp_status),
      .rsp_speed           (rsp_speed),
      .rsp_unknown_command (rsp_unknown_command)
   );

endmodule
